@@ rtl/touch_key_debounce_hold_macros.svh @@
// Assertion shorthands; expect clk and rst_n in the enclosing scope.
`ifndef TOUCH_KEY_DEBOUNCE_HOLD_MACROS_SVH
`define TOUCH_KEY_DEBOUNCE_HOLD_MACROS_SVH

// same-cycle implication
`define TKDH_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tkdh check failed");

// next-cycle implication
`define TKDH_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tkdh check failed");

`endif

@@ rtl/tkdh_pkg.sv @@
package tkdh_pkg;

    // calibration
    localparam int CAL_SAMPLES = 10;
    localparam int SUM_W       = 20;
    localparam int CNT_W       = (CAL_SAMPLES > 1) ? $clog2(CAL_SAMPLES) : 1;
    // sum / CAL_SAMPLES as multiply by rounded-up reciprocal, exact for SUM_W-bit sums
    localparam int CAL_DIV_SH  = SUM_W + $clog2(CAL_SAMPLES);
    localparam longint unsigned CAL_RECIP =
        ((64'd1 << CAL_DIV_SH) + 64'(CAL_SAMPLES) - 64'd1) / 64'(CAL_SAMPLES);
    localparam int RECIP_W     = CAL_DIV_SH + 1;
    localparam int PROD_W      = SUM_W + RECIP_W;

    localparam int VAL_W  = 16;
    localparam int TIME_W = 32;

    // register reset values
    localparam logic [VAL_W-1:0] DEF_DEBOUNCE = 16'd150;
    localparam logic [VAL_W-1:0] DEF_HOLD     = 16'd2000;
    localparam logic [VAL_W-1:0] DEF_OFFSET   = 16'd20;
    localparam logic [VAL_W-1:0] DEF_MIN_LVL  = 16'd40;
    localparam logic [VAL_W-1:0] DEF_FAILSAFE = 16'd15;

    typedef enum logic [2:0] {
        REG_DEBOUNCE = 3'd0,
        REG_HOLD     = 3'd1,
        REG_OFFSET   = 3'd2,
        REG_MIN_LVL  = 3'd3,
        REG_FAILSAFE = 3'd4
    } cfg_idx_t;

    typedef enum logic [1:0] {
        KEY_OFF     = 2'd0,
        KEY_JITTER  = 2'd1,
        KEY_TOUCHED = 2'd2,
        KEY_HOLD    = 2'd3
    } key_state_t;

    typedef enum logic [1:0] {
        EV_TOUCHED  = 2'd0,
        EV_HOLD     = 2'd1,
        EV_RELEASED = 2'd2,
        EV_CALDONE  = 2'd3
    } event_kind_t;

    typedef enum logic {
        FUNC_DETECT    = 1'b0,
        FUNC_CALIBRATE = 1'b1
    } func_t;

    typedef struct packed {
        logic [VAL_W-1:0] debounce_ms;
        logic [VAL_W-1:0] hold_ms;
        logic [VAL_W-1:0] cal_offset;
        logic [VAL_W-1:0] cal_min_level;
        logic [VAL_W-1:0] failsafe_threshold;
    } cfg_t;

    typedef struct packed {
        logic              func;
        logic [VAL_W-1:0]  sample_value;
        logic [TIME_W-1:0] now_ms;
    } in_item_t;

    // input stage handoff to the core
    typedef struct packed {
        logic     valid;
        in_item_t item;
    } stage_t;

endpackage

@@ rtl/tkdh_if.sv @@
interface tkdh_in_if;
    import tkdh_pkg::*;

    logic              valid;
    logic              ready;
    logic              func;
    logic [VAL_W-1:0]  sample_value;
    logic [TIME_W-1:0] now_ms;

    modport source (output valid, func, sample_value, now_ms, input ready);
    modport sink   (input valid, func, sample_value, now_ms, output ready);
endinterface

interface tkdh_out_if;
    import tkdh_pkg::*;

    logic             valid;
    logic             ready;
    logic [1:0]       event_kind;
    logic [VAL_W-1:0] touch_threshold;

    modport source (output valid, event_kind, touch_threshold, input ready);
    modport sink   (input valid, event_kind, touch_threshold, output ready);
endinterface

@@ rtl/tkdh_cfg_regs.sv @@
module tkdh_cfg_regs
    import tkdh_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  cfg_idx_t         cfg_index,
    input  logic [VAL_W-1:0] cfg_data,
    output cfg_t             cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_DEBOUNCE: cfg_next.debounce_ms        = cfg_data;
                REG_HOLD:     cfg_next.hold_ms            = cfg_data;
                REG_OFFSET:   cfg_next.cal_offset         = cfg_data;
                REG_MIN_LVL:  cfg_next.cal_min_level      = cfg_data;
                REG_FAILSAFE: cfg_next.failsafe_threshold = cfg_data;
                default:      cfg_next = cfg_reg;  // unused index
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_ms        <= DEF_DEBOUNCE;
            cfg_reg.hold_ms            <= DEF_HOLD;
            cfg_reg.cal_offset         <= DEF_OFFSET;
            cfg_reg.cal_min_level      <= DEF_MIN_LVL;
            cfg_reg.failsafe_threshold <= DEF_FAILSAFE;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ rtl/tkdh_in_stage.sv @@
module tkdh_in_stage
    import tkdh_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    tkdh_in_if.sink   samples,
    input  logic      advance,
    output stage_t    stage
);

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;
    logic     take;

    // stage frees up whenever the core can move its item along
    assign samples.ready = !valid_reg || advance;
    assign take          = samples.valid && samples.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
            valid_next = 1'b1;
        else if (advance)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg.func         <= samples.func;
            item_reg.sample_value <= samples.sample_value;
            item_reg.now_ms       <= samples.now_ms;
        end
    end

    assign stage.valid = valid_reg;
    assign stage.item  = item_reg;

endmodule

@@ rtl/tkdh_core.sv @@
module tkdh_core
    import tkdh_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    input  stage_t    stage,
    output logic      advance,
    tkdh_out_if.source events
);

    key_state_t        key_reg,       key_next;
    logic [TIME_W-1:0] start_reg,     start_next;
    logic [VAL_W-1:0]  thr_reg,       thr_next;
    logic [SUM_W-1:0]  sum_reg,       sum_next;
    logic [CNT_W-1:0]  cnt_reg,       cnt_next;
    logic              out_valid_reg, out_valid_next;
    event_kind_t       ev_reg,        ev_next;
    logic [VAL_W-1:0]  out_thr_reg;

    logic              fire;
    logic              emit;
    logic [SUM_W-1:0]  sum_acc;
    logic [PROD_W-1:0] prod;
    logic [SUM_W-1:0]  avg;
    logic [VAL_W-1:0]  thr_cal;
    logic [TIME_W-1:0] elapsed;
    logic              touch;

    assign advance = !out_valid_reg || events.ready;
    assign fire    = stage.valid && advance;

    // calibration datapath
    assign sum_acc = sum_reg + SUM_W'(stage.item.sample_value);
    assign prod    = PROD_W'(sum_acc) * PROD_W'(CAL_RECIP);
    assign avg     = prod[CAL_DIV_SH +: SUM_W];

    always_comb
    begin
        if (avg > SUM_W'(cfg.cal_min_level))
        begin
            if (avg > SUM_W'(cfg.cal_offset))
                thr_cal = VAL_W'(avg - SUM_W'(cfg.cal_offset));
            else
                thr_cal = '0;
        end
        else
        begin
            thr_cal = cfg.failsafe_threshold;
        end
    end

    // detect datapath
    assign elapsed = stage.item.now_ms - start_reg;
    assign touch   = stage.item.sample_value < thr_reg;

    always_comb
    begin
        key_next   = key_reg;
        start_next = start_reg;
        thr_next   = thr_reg;
        sum_next   = sum_reg;
        cnt_next   = cnt_reg;
        emit       = 1'b0;
        ev_next    = ev_reg;

        if (fire)
        begin
            if (stage.item.func == FUNC_CALIBRATE)
            begin
                if (cnt_reg == CNT_W'(CAL_SAMPLES - 1))
                begin
                    thr_next = thr_cal;
                    sum_next = '0;
                    cnt_next = '0;
                    emit     = 1'b1;
                    ev_next  = EV_CALDONE;
                end
                else
                begin
                    sum_next = sum_acc;
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            else if (touch)
            begin
                unique case (key_reg)
                    KEY_OFF:
                    begin
                        key_next   = KEY_JITTER;
                        start_next = stage.item.now_ms;
                    end
                    KEY_JITTER:
                    begin
                        if (elapsed > TIME_W'(cfg.debounce_ms))
                        begin
                            key_next = KEY_TOUCHED;
                            emit     = 1'b1;
                            ev_next  = EV_TOUCHED;
                        end
                    end
                    KEY_TOUCHED:
                    begin
                        if (elapsed > TIME_W'(cfg.hold_ms))
                        begin
                            key_next = KEY_HOLD;
                            emit     = 1'b1;
                            ev_next  = EV_HOLD;
                        end
                    end
                    default: key_next = key_reg;  // hold stays put
                endcase
            end
            else
            begin
                key_next = KEY_OFF;
                if (key_reg == KEY_TOUCHED || key_reg == KEY_HOLD)
                begin
                    emit    = 1'b1;
                    ev_next = EV_RELEASED;
                end
            end
        end

        out_valid_next = out_valid_reg;
        if (fire && emit)
            out_valid_next = 1'b1;
        else if (events.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg       <= KEY_OFF;
            start_reg     <= '0;
            thr_reg       <= DEF_FAILSAFE;
            sum_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            key_reg       <= key_next;
            start_reg     <= start_next;
            thr_reg       <= thr_next;
            sum_reg       <= sum_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload, loaded only when a result is produced
    always_ff @(posedge clk)
    begin
        if (fire && emit)
        begin
            ev_reg      <= ev_next;
            out_thr_reg <= thr_next;
        end
    end

    assign events.valid           = out_valid_reg;
    assign events.event_kind      = ev_reg;
    assign events.touch_threshold = out_thr_reg;

endmodule

@@ rtl/touch_key_debounce_hold.sv @@
// Touch key debounce and long-press detector with threshold calibration.
// Each sample transfer carries func, sample_value and now_ms. A detect sample
// (func 0) counts as a touch when sample_value is below the current threshold;
// the key walks off -> jitter -> touched -> hold, reporting touched once the
// touch has lasted more than debounce_ms, hold once more than hold_ms from
// onset, and released when a touched or held key lets go. A calibrate sample
// (func 1) adds to a running sum; every CAL_SAMPLES-th one sets the threshold
// to the truncated average less cal_offset, floored at zero, or to
// failsafe_threshold when the average is not above cal_min_level, and reports
// calibration done. Every result carries the threshold in effect after its
// sample. Throughput is one sample per clock: the sample is held in the input
// register, then the key state, calibration sum and threshold update as the
// result lands in the output register. Samples that give no result produce no
// event transfer. The only thing that slows the input is a result held in the
// output register while the event sink is not ready. Configuration writes
// take effect on the next clock and must only be done while no sample is in
// flight. No clearing pass after reset.
module touch_key_debounce_hold
    import tkdh_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    tkdh_in_if.sink           samples,
    tkdh_out_if.source        events,
    input  logic              cfg_we,
    input  logic [2:0]        cfg_index,
    input  logic [VAL_W-1:0]  cfg_data
);

    cfg_t   cfg;
    stage_t stage;
    logic   advance;

    // configuration register file
    tkdh_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_idx_t'(cfg_index)),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // input register; ready follows the core's ability to move along
    tkdh_in_stage u_in (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (samples),
        .advance (advance),
        .stage   (stage)
    );

    // key state machine, calibration and result register
    tkdh_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .stage   (stage),
        .advance (advance),
        .events  (events)
    );

endmodule

@@ rtl/tkdh_checker.sv @@
`include "touch_key_debounce_hold_macros.svh"

module tkdh_checker
    import tkdh_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_ready,
    input logic             out_valid,
    input logic             out_ready,
    input logic [1:0]       event_kind,
    input logic [VAL_W-1:0] touch_threshold
);

    logic             in_xfer;
    logic [VAL_W+1:0] out_payload;
    assign in_xfer     = in_valid && in_ready;
    assign out_payload = {event_kind, touch_threshold};

    // stalled result keeps its payload
    `TKDH_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_payload))

    // an empty output register never blocks the input
    `TKDH_ASSERT_IMP(a_ready_when_empty, !out_valid, in_ready)

    // a fresh result follows its sample transfer through the input and output registers
    `TKDH_ASSERT_IMP(a_result_latency, $rose(out_valid), $past(in_xfer, 2))

    // a result with a free sink leaves room for the next sample
    `TKDH_ASSERT_IMP(a_ready_when_drain, out_valid && out_ready, in_ready)

endmodule

bind touch_key_debounce_hold tkdh_checker u_tkdh_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (samples.valid),
    .in_ready        (samples.ready),
    .out_valid       (events.valid),
    .out_ready       (events.ready),
    .event_kind      (events.event_kind),
    .touch_threshold (events.touch_threshold)
);
